>>> sv/cbfs_pkg.sv
// Shared types, constants and codes for the chained block file store.
`timescale 1ns / 1ps

package cbfs_pkg;

    localparam int NUM_FILES   = 64;
    localparam int BLOCK_COUNT = 128;
    localparam int BLOCK_BYTES = 64;

    localparam int FILE_W  = $clog2(NUM_FILES);
    localparam int BLK_W   = $clog2(BLOCK_COUNT);
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int DADDR_W = BLK_W + OFF_W;
    localparam int LEN_W   = 14;
    localparam int POS_W   = 13;
    localparam int LINK_W  = 8;
    localparam int NBLK_W  = 8;
    localparam int WANT_W  = 9;

    localparam logic [LINK_W-1:0] LINK_FREE = 8'hFF;
    localparam logic [LINK_W-1:0] LINK_END  = 8'hFE;
    localparam logic [LINK_W-1:0] HEAD_FREE = 8'hFF;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_SIZE   = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FILE   = 3'd1;
    localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_PAST_LEN  = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  file_id;
        logic [12:0] position;
        logic [13:0] new_size;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_file;
        logic [7:0]  read_data;
        logic [13:0] current_length;
        logic [13:0] current_capacity;
    } t_rsp;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [NBLK_W-1:0] nblk;
        logic [LEN_W-1:0]  len;
    } t_fent;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_FSCAN_RD, S_FSCAN_CHK, S_BSCAN_RD, S_BSCAN_CHK,
        S_FCHK, S_DECIDE, S_TWALK_RD, S_TWALK_CHK, S_TAIL, S_GROW_RD, S_GROW_CHK,
        S_GROW_LINK, S_SHR_RD, S_SHR_CHK, S_SHR_END, S_RESIZED, S_DWALK_RD,
        S_DWALK_CHK, S_DATA, S_DATA_CHK, S_FWRITE, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_FRD_IDX, OP_FRD_REQ, OP_IDX_INC, OP_FOUND_FILE,
        OP_NO_FILE, OP_NO_BLOCK_NEW, OP_NO_BLOCK, OP_LRD_IDX, OP_LRD_BLK,
        OP_CREATE_TAKE, OP_NOT_ALLOC, OP_LATCH_FILE, OP_SET_TAIL_GROW,
        OP_SET_TAIL_SHRINK, OP_SET_DWALK, OP_PAST_LEN, OP_WALK, OP_TAIL,
        OP_GROW_TAKE, OP_GROW_LINK, OP_SHR_STEP, OP_SHR_END, OP_CLAMP,
        OP_DATA_WR, OP_DATA_RD, OP_RDATA, OP_FWR
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic       sweep_last;
        logic       head_free;
        logic       lrd_free;
        logic       lrd_valid;
        logic       idx_file_last;
        logic       free_none;
        logic       grow;
        logic       shrink;
        logic       enough;
        logic       past_cap;
        logic       past_len;
        logic       cnt_zero;
        logic       at_want;
    } t_stat;

endpackage

>>> sv/chained_block_file_store.sv
// Top level of the chained block file store: controller plus datapath.
`timescale 1ns / 1ps

// A request beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on o_rsp for one cycle with o_done high, and the
// receiver cannot stall it. After reset the block runs a clearing pass over
// all 8192 bytes of the block store (one byte per cycle, also resetting the
// file and link tables) with busy high. Every step through the file table or
// a block chain is a registered read of a table followed by a check:
// creating a file scans the file table and then the link table for a free
// block; set size, write and read walk the chain link by link, growing also
// scans for free blocks and links each one, and shrinking frees the blocks
// past the new tail one by one. A write that grows walks the chain twice,
// once to the tail and once to the target block.
module chained_block_file_store import cbfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_op   op;
    t_stat stat;

    // sequencer: one datapath command per cycle
    cbfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // tables, byte store and result registers
    cbfs_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_req   (i_req),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule

>>> sv/cbfs_dpath.sv
// Datapath: file table, link table, byte store and working registers.
`timescale 1ns / 1ps

module cbfs_dpath import cbfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_op   i_op,
    input  t_req  i_req,
    output t_stat o_stat,
    output t_rsp  o_rsp
);

    t_fent             r_file_mem [NUM_FILES];
    logic [LINK_W-1:0] r_link_mem [BLOCK_COUNT];
    logic [7:0]        r_data_mem [BLOCK_COUNT*BLOCK_BYTES];

    t_fent             r_frd;
    logic [LINK_W-1:0] r_lrd;
    logic [7:0]        r_drd;

    t_req               r_req;
    logic [DADDR_W-1:0] r_sweep;
    logic [BLK_W-1:0]   r_idx;
    logic [FILE_W-1:0]  r_fidx;
    logic [LINK_W-1:0]  r_head;
    logic [NBLK_W-1:0]  r_nblk;
    logic [LEN_W-1:0]   r_len;
    logic [LINK_W-1:0]  r_blk;
    logic [LINK_W-1:0]  r_tail;
    logic [BLK_W-1:0]   r_cnt;
    logic [WANT_W-1:0]  r_want;
    logic [NBLK_W-1:0]  r_free;
    logic [2:0]         r_status;
    logic [7:0]         r_rdata;

    logic               f_we, f_re, l_we, l_re, d_we, d_re;
    logic [FILE_W-1:0]  f_waddr, f_raddr;
    t_fent              f_wdata;
    logic [BLK_W-1:0]   l_waddr, l_raddr;
    logic [LINK_W-1:0]  l_wdata;
    logic [DADDR_W-1:0] d_addr;
    logic [7:0]         d_wdata;
    logic [LEN_W:0]     size_up;
    logic [WANT_W-1:0]  want_calc;
    logic [LEN_W-1:0]   pos_end;

    always_comb begin
        size_up = {1'b0, r_req.new_size} + (LEN_W+1)'(BLOCK_BYTES - 1);
        if (r_req.mode == MODE_SIZE) begin
            want_calc = size_up[LEN_W:OFF_W] + WANT_W'(0);
            if (want_calc == '0) begin
                want_calc = WANT_W'(1);
            end
        end else begin
            want_calc = WANT_W'(r_req.position[POS_W-1:OFF_W]) + WANT_W'(1);
        end
        pos_end = LEN_W'(r_req.position) + LEN_W'(1);
    end

    always_comb begin
        f_we = 1'b0; f_re = 1'b0; l_we = 1'b0; l_re = 1'b0; d_we = 1'b0; d_re = 1'b0;
        f_waddr = r_fidx;
        f_raddr = r_idx[FILE_W-1:0];
        f_wdata = '{head: r_head, nblk: r_nblk, len: r_len};
        l_waddr = r_idx;
        l_raddr = r_idx;
        l_wdata = LINK_END;
        d_addr  = {r_blk[BLK_W-1:0], r_req.position[OFF_W-1:0]};
        d_wdata = r_req.write_data;
        case (i_op)
            OP_CLEAR: begin
                f_we    = 1'b1;
                f_waddr = r_sweep[FILE_W-1:0];
                f_wdata = (r_sweep[FILE_W-1:0] == '0)
                        ? '{head: '0, nblk: NBLK_W'(1), len: '0}
                        : '{head: HEAD_FREE, nblk: '0, len: '0};
                l_we    = 1'b1;
                l_waddr = r_sweep[BLK_W-1:0];
                l_wdata = (r_sweep[BLK_W-1:0] == '0) ? LINK_END : LINK_FREE;
                d_we    = 1'b1;
                d_addr  = r_sweep;
                d_wdata = '0;
            end
            OP_FRD_IDX:     f_re = 1'b1;
            OP_FRD_REQ: begin
                f_re    = 1'b1;
                f_raddr = r_req.file_id;
            end
            OP_LRD_IDX:     l_re = 1'b1;
            OP_LRD_BLK: begin
                l_re    = 1'b1;
                l_raddr = r_blk[BLK_W-1:0];
            end
            OP_CREATE_TAKE, OP_GROW_TAKE: l_we = 1'b1;
            OP_GROW_LINK: begin
                l_we    = 1'b1;
                l_waddr = r_tail[BLK_W-1:0];
                l_wdata = LINK_W'(r_idx);
            end
            OP_SHR_STEP: begin
                l_we    = (r_blk != r_tail);
                l_waddr = r_blk[BLK_W-1:0];
                l_wdata = LINK_FREE;
            end
            OP_SHR_END: begin
                l_we    = 1'b1;
                l_waddr = r_tail[BLK_W-1:0];
            end
            OP_DATA_WR:     d_we = 1'b1;
            OP_DATA_RD:     d_re = 1'b1;
            OP_FWR:         f_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_file_mem[f_waddr] <= f_wdata;
        end
        if (f_re) begin
            r_frd <= r_file_mem[f_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_link_mem[l_waddr] <= l_wdata;
        end
        if (l_re) begin
            r_lrd <= r_link_mem[l_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_data_mem[d_addr] <= d_wdata;
        end
        if (d_re) begin
            r_drd <= r_data_mem[d_addr];
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_free  <= NBLK_W'(BLOCK_COUNT - 1);
        end else begin
            case (i_op)
                OP_CLEAR:                     r_sweep <= r_sweep + DADDR_W'(1);
                OP_CREATE_TAKE, OP_GROW_TAKE: r_free  <= r_free - NBLK_W'(1);
                OP_SHR_STEP: begin
                    if (r_blk != r_tail) begin
                        r_free <= r_free + NBLK_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_req    <= i_req;
                r_idx    <= '0;
                r_fidx   <= i_req.file_id;
                r_status <= ST_OK;
                r_rdata  <= '0;
            end
            OP_IDX_INC:    r_idx <= r_idx + BLK_W'(1);
            OP_FOUND_FILE: begin
                r_fidx <= r_idx[FILE_W-1:0];
                r_idx  <= '0;
            end
            OP_NO_FILE, OP_NO_BLOCK_NEW: begin
                r_status <= (i_op == OP_NO_FILE) ? ST_NO_FILE : ST_NO_BLOCK;
                r_fidx   <= '0;
                r_len    <= '0;
                r_nblk   <= '0;
            end
            OP_NO_BLOCK:   r_status <= ST_NO_BLOCK;
            OP_NOT_ALLOC: begin
                r_status <= ST_NOT_ALLOC;
                r_len    <= '0;
                r_nblk   <= '0;
            end
            OP_PAST_LEN:   r_status <= ST_PAST_LEN;
            OP_CREATE_TAKE: begin
                r_head <= LINK_W'(r_idx);
                r_nblk <= NBLK_W'(1);
                r_len  <= '0;
            end
            OP_LATCH_FILE: begin
                r_head <= r_frd.head;
                r_nblk <= r_frd.nblk;
                r_len  <= r_frd.len;
                r_want <= want_calc;
            end
            OP_SET_TAIL_GROW: begin
                r_blk <= r_head;
                r_cnt <= BLK_W'(r_nblk - NBLK_W'(1));
            end
            OP_SET_TAIL_SHRINK: begin
                r_blk <= r_head;
                r_cnt <= BLK_W'(r_want - WANT_W'(1));
            end
            OP_SET_DWALK: begin
                r_blk <= r_head;
                r_cnt <= r_req.position[POS_W-1:OFF_W];
            end
            OP_WALK: begin
                r_blk <= r_lrd;
                r_cnt <= r_cnt - BLK_W'(1);
            end
            OP_TAIL: begin
                r_tail <= r_blk;
                r_idx  <= '0;
            end
            OP_GROW_LINK: begin
                r_tail <= LINK_W'(r_idx);
                r_nblk <= r_nblk + NBLK_W'(1);
                r_idx  <= r_idx + BLK_W'(1);
            end
            OP_SHR_STEP:   r_blk <= r_lrd;
            OP_SHR_END:    r_nblk <= NBLK_W'(r_want);
            OP_CLAMP: begin
                if (r_len > r_req.new_size) begin
                    r_len <= r_req.new_size;
                end
            end
            OP_DATA_WR: begin
                if (LEN_W'(r_req.position) >= r_len) begin
                    r_len <= pos_end;
                end
            end
            OP_RDATA:      r_rdata <= r_drd;
            default: ;
        endcase
    end

    always_comb begin
        o_stat.mode          = r_req.mode;
        o_stat.sweep_last    = (r_sweep == '1);
        o_stat.head_free     = (r_frd.head == HEAD_FREE);
        o_stat.lrd_free      = (r_lrd == LINK_FREE);
        o_stat.lrd_valid     = (r_lrd < LINK_W'(BLOCK_COUNT));
        o_stat.idx_file_last = (r_idx[FILE_W-1:0] == FILE_W'(NUM_FILES - 1));
        o_stat.free_none     = (r_free == '0);
        o_stat.grow          = (r_want > WANT_W'(r_nblk));
        o_stat.shrink        = (r_want < WANT_W'(r_nblk));
        o_stat.enough        = (WANT_W'(r_free) >= (r_want - WANT_W'(r_nblk)));
        o_stat.past_cap      = (NBLK_W'(r_req.position[POS_W-1:OFF_W]) >= r_nblk);
        o_stat.past_len      = (LEN_W'(r_req.position) >= r_len);
        o_stat.cnt_zero      = (r_cnt == '0);
        o_stat.at_want       = (WANT_W'(r_nblk) == r_want);
    end

    assign o_rsp.status           = r_status;
    assign o_rsp.result_file      = r_fidx;
    assign o_rsp.read_data        = r_rdata;
    assign o_rsp.current_length   = r_len;
    assign o_rsp.current_capacity = LEN_W'({r_nblk, {OFF_W{1'b0}}});

endmodule

>>> sv/cbfs_ctrl.sv
// Controller: sequences each request over the datapath.
`timescale 1ns / 1ps

module cbfs_ctrl import cbfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (i_stat.sweep_last) n_state = S_IDLE;
            S_IDLE:      if (i_start) n_state = S_DISPATCH;
            S_DISPATCH:  n_state = (i_stat.mode == MODE_CREATE) ? S_FSCAN_CHK : S_FCHK;
            S_FSCAN_RD:  n_state = S_FSCAN_CHK;
            S_FSCAN_CHK: begin
                if (i_stat.head_free) begin
                    n_state = i_stat.free_none ? S_DONE : S_BSCAN_RD;
                end else begin
                    n_state = i_stat.idx_file_last ? S_DONE : S_FSCAN_RD;
                end
            end
            S_BSCAN_RD:  n_state = S_BSCAN_CHK;
            S_BSCAN_CHK: n_state = i_stat.lrd_free ? S_FWRITE : S_BSCAN_RD;
            S_FCHK:      n_state = i_stat.head_free ? S_DONE : S_DECIDE;
            S_DECIDE: begin
                unique case (i_stat.mode)
                    MODE_SIZE: begin
                        if (i_stat.grow) begin
                            n_state = i_stat.enough ? S_TWALK_RD : S_DONE;
                        end else begin
                            n_state = i_stat.shrink ? S_TWALK_RD : S_RESIZED;
                        end
                    end
                    MODE_WRITE: begin
                        if (i_stat.past_cap) begin
                            n_state = i_stat.enough ? S_TWALK_RD : S_DONE;
                        end else begin
                            n_state = S_DWALK_RD;
                        end
                    end
                    default:     n_state = i_stat.past_len ? S_DONE : S_DWALK_RD;
                endcase
            end
            S_TWALK_RD:  n_state = i_stat.cnt_zero ? S_TAIL : S_TWALK_CHK;
            S_TWALK_CHK: n_state = S_TWALK_RD;
            S_TAIL:      n_state = i_stat.grow ? S_GROW_RD : S_SHR_RD;
            S_GROW_RD:   n_state = i_stat.at_want ? S_RESIZED : S_GROW_CHK;
            S_GROW_CHK:  n_state = i_stat.lrd_free ? S_GROW_LINK : S_GROW_RD;
            S_GROW_LINK: n_state = S_GROW_RD;
            S_SHR_RD:    n_state = S_SHR_CHK;
            S_SHR_CHK:   n_state = i_stat.lrd_valid ? S_SHR_RD : S_SHR_END;
            S_SHR_END:   n_state = S_RESIZED;
            S_RESIZED:   n_state = (i_stat.mode == MODE_SIZE) ? S_FWRITE : S_DWALK_RD;
            S_DWALK_RD:  n_state = i_stat.cnt_zero ? S_DATA : S_DWALK_CHK;
            S_DWALK_CHK: n_state = S_DWALK_RD;
            S_DATA:      n_state = (i_stat.mode == MODE_WRITE) ? S_FWRITE : S_DATA_CHK;
            S_DATA_CHK:  n_state = S_DONE;
            S_FWRITE:    n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = OP_NONE;
        o_busy = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
        unique case (r_state)
            S_CLEAR:     o_op = OP_CLEAR;
            S_IDLE:      if (i_start) o_op = OP_LOAD;
            S_DISPATCH:  o_op = (i_stat.mode == MODE_CREATE) ? OP_FRD_IDX : OP_FRD_REQ;
            S_FSCAN_RD:  o_op = OP_FRD_IDX;
            S_FSCAN_CHK: begin
                if (i_stat.head_free) begin
                    o_op = i_stat.free_none ? OP_NO_BLOCK_NEW : OP_FOUND_FILE;
                end else begin
                    o_op = i_stat.idx_file_last ? OP_NO_FILE : OP_IDX_INC;
                end
            end
            S_BSCAN_RD:  o_op = OP_LRD_IDX;
            S_BSCAN_CHK: o_op = i_stat.lrd_free ? OP_CREATE_TAKE : OP_IDX_INC;
            S_FCHK:      o_op = i_stat.head_free ? OP_NOT_ALLOC : OP_LATCH_FILE;
            S_DECIDE: begin
                unique case (i_stat.mode)
                    MODE_SIZE: begin
                        if (i_stat.grow) begin
                            o_op = i_stat.enough ? OP_SET_TAIL_GROW : OP_NO_BLOCK;
                        end else if (i_stat.shrink) begin
                            o_op = OP_SET_TAIL_SHRINK;
                        end
                    end
                    MODE_WRITE: begin
                        if (i_stat.past_cap) begin
                            o_op = i_stat.enough ? OP_SET_TAIL_GROW : OP_NO_BLOCK;
                        end else begin
                            o_op = OP_SET_DWALK;
                        end
                    end
                    default:     o_op = i_stat.past_len ? OP_PAST_LEN : OP_SET_DWALK;
                endcase
            end
            S_TWALK_RD:  if (!i_stat.cnt_zero) o_op = OP_LRD_BLK;
            S_TWALK_CHK: o_op = OP_WALK;
            S_TAIL:      o_op = OP_TAIL;
            S_GROW_RD:   if (!i_stat.at_want) o_op = OP_LRD_IDX;
            S_GROW_CHK:  o_op = i_stat.lrd_free ? OP_GROW_TAKE : OP_IDX_INC;
            S_GROW_LINK: o_op = OP_GROW_LINK;
            S_SHR_RD:    o_op = OP_LRD_BLK;
            S_SHR_CHK:   o_op = OP_SHR_STEP;
            S_SHR_END:   o_op = OP_SHR_END;
            S_RESIZED:   o_op = (i_stat.mode == MODE_SIZE) ? OP_CLAMP : OP_SET_DWALK;
            S_DWALK_RD:  if (!i_stat.cnt_zero) o_op = OP_LRD_BLK;
            S_DWALK_CHK: o_op = OP_WALK;
            S_DATA:      o_op = (i_stat.mode == MODE_WRITE) ? OP_DATA_WR : OP_DATA_RD;
            S_DATA_CHK:  o_op = OP_RDATA;
            S_FWRITE:    o_op = OP_FWR;
            S_DONE:      o_op = OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end

endmodule

>>> tb/sv/chained_block_file_store_tb.sv
// Self-checking testbench for the chained block file store.
`timescale 1ns / 1ps

module chained_block_file_store_tb;
    import cbfs_pkg::*;

    // Run limit in cycles, set far above what the clearing pass and all the
    // requests of the whole run need.
    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int RANDOM_BEATS = 1400;
    localparam int DRAIN_CYCLES = 600;

    // Shadow of the file and block tables. It predicts each response and keeps
    // the expected responses in order until they are checked.
    class fat_scoreboard;
        logic [7:0] head_of[NUM_FILES];
        int         cap_of[NUM_FILES];
        int         len_of[NUM_FILES];
        logic [7:0] next_of[BLOCK_COUNT];
        logic [7:0] store[BLOCK_COUNT * BLOCK_BYTES];
        t_rsp       pending_rsp[$];
        int         mismatches;

        function new();
            foreach (head_of[i]) begin
                head_of[i] = HEAD_FREE;
                cap_of[i]  = 0;
                len_of[i]  = 0;
            end
            foreach (next_of[i]) next_of[i] = LINK_FREE;
            foreach (store[i]) store[i] = 8'h00;
            head_of[0] = 8'd0;
            cap_of[0]  = BLOCK_BYTES;
            next_of[0] = LINK_END;
            mismatches = 0;
        endfunction

        function int lowest_free_block();
            for (int i = 0; i < BLOCK_COUNT; i++)
                if (next_of[i] == LINK_FREE) return i;
            return BLOCK_COUNT;
        endfunction

        function int free_blocks();
            int n;
            n = 0;
            for (int i = 0; i < BLOCK_COUNT; i++)
                if (next_of[i] == LINK_FREE) n++;
            return n;
        endfunction

        // Follow k links from the file head; stops at the chain end.
        function int chain_block(int f, int k);
            int b;
            b = head_of[f];
            while (k > 0 && b < BLOCK_COUNT && next_of[b] < BLOCK_COUNT) begin
                b = next_of[b];
                k--;
            end
            return b;
        endfunction

        // All or nothing: returns 0 with no change when short of blocks.
        function bit resize(int f, int size);
            int want, have, tail, nb, n, nxt;
            want = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
            have = cap_of[f] / BLOCK_BYTES;
            if (want == 0) want = 1;
            if (have == 0) have = 1;
            if (want > have) begin
                if (free_blocks() < want - have) return 0;
                tail = chain_block(f, have - 1);
                for (n = have; n < want && tail < BLOCK_COUNT; n++) begin
                    nb = lowest_free_block();
                    if (nb >= BLOCK_COUNT) break;
                    next_of[tail] = nb[7:0];
                    next_of[nb]   = LINK_END;
                    tail = nb;
                end
            end else if (want < have) begin
                tail = chain_block(f, want - 1);
                if (tail < BLOCK_COUNT) begin
                    nb = next_of[tail];
                    n = 0;
                    while (nb < BLOCK_COUNT && n < BLOCK_COUNT) begin
                        nxt = next_of[nb];
                        next_of[nb] = LINK_FREE;
                        nb = nxt;
                        n++;
                    end
                    next_of[tail] = LINK_END;
                end
            end
            cap_of[f] = want * BLOCK_BYTES;
            return 1;
        endfunction

        // Accepted request beat: update the shadow and queue the expected response.
        function void note_request(t_req r);
            t_rsp e;
            int f, pos, size, b, i;
            f = r.file_id;
            pos = r.position;
            size = r.new_size;
            e = '0;
            e.status = ST_OK;
            e.result_file = r.file_id;
            if (r.mode == MODE_CREATE) begin
                e.result_file = '0;
                for (i = 0; i < NUM_FILES; i++)
                    if (head_of[i] == HEAD_FREE) break;
                if (i >= NUM_FILES) begin
                    e.status = ST_NO_FILE;
                end else begin
                    b = lowest_free_block();
                    if (b >= BLOCK_COUNT) begin
                        e.status = ST_NO_BLOCK;
                    end else begin
                        head_of[i] = b[7:0];
                        next_of[b] = LINK_END;
                        cap_of[i] = BLOCK_BYTES;
                        len_of[i] = 0;
                        e.result_file = i[5:0];
                        e.current_capacity = 14'(BLOCK_BYTES);
                    end
                end
            end else if (f >= NUM_FILES || head_of[f] == HEAD_FREE) begin
                e.status = ST_NOT_ALLOC;
            end else begin
                case (r.mode)
                    MODE_SIZE: begin
                        if (!resize(f, size)) e.status = ST_NO_BLOCK;
                        else if (len_of[f] > size) len_of[f] = size;
                    end
                    MODE_WRITE: begin
                        if (pos >= cap_of[f] && !resize(f, pos + 1)) begin
                            e.status = ST_NO_BLOCK;
                        end else begin
                            b = chain_block(f, pos / BLOCK_BYTES);
                            if (b < BLOCK_COUNT)
                                store[b * BLOCK_BYTES + pos % BLOCK_BYTES] = r.write_data;
                            if (pos >= len_of[f]) len_of[f] = pos + 1;
                        end
                    end
                    default: begin
                        if (pos >= len_of[f]) begin
                            e.status = ST_PAST_LEN;
                        end else begin
                            b = chain_block(f, pos / BLOCK_BYTES);
                            if (b < BLOCK_COUNT)
                                e.read_data = store[b * BLOCK_BYTES + pos % BLOCK_BYTES];
                        end
                    end
                endcase
                e.current_length   = len_of[f][13:0];
                e.current_capacity = cap_of[f][13:0];
            end
            pending_rsp.push_back(e);
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (pending_rsp.size() == 0) begin
                $error("response beat with nothing pending: %h", a);
                mismatches++;
                return;
            end
            e = pending_rsp.pop_front();
            if (a.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, a.status);
                mismatches++;
            end
            if (a.result_file !== e.result_file) begin
                $error("result_file: expected %0d, got %0d", e.result_file, a.result_file);
                mismatches++;
            end
            if (a.read_data !== e.read_data) begin
                $error("read_data: expected %0h, got %0h", e.read_data, a.read_data);
                mismatches++;
            end
            if (a.current_length !== e.current_length) begin
                $error("current_length: expected %0d, got %0d",
                       e.current_length, a.current_length);
                mismatches++;
            end
            if (a.current_capacity !== e.current_capacity) begin
                $error("current_capacity: expected %0d, got %0d",
                       e.current_capacity, a.current_capacity);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    fat_scoreboard fat_sb;
    longint unsigned cycle_count;

    chained_block_file_store dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog; also covers a hang in the final drain.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chained_block_file_store regression: fail");
            $finish;
        end
    end

    // Response monitor: o_done is a one-cycle strobe, sampled at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) fat_sb.check_result(o_rsp);
    end

    // Present one request beat and hold it until busy is low at an edge.
    // start stays high on return so a burst can chain straight on.
    task automatic send_beat(t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        fat_sb.note_request(r);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_req mk_req(logic [1:0] m, int f, int pos, int size, int wd);
        t_req r;
        r.mode = m;
        r.file_id = f[5:0];
        r.position = pos[12:0];
        r.new_size = size[13:0];
        r.write_data = wd[7:0];
        return r;
    endfunction

    // Random request; mostly targets live files near their current extent.
    function automatic t_req rand_req();
        t_req r;
        int pick, f, lim, tries;
        r.mode = MODE_CREATE;
        r.file_id = 6'($urandom);
        r.position = 13'($urandom);
        r.write_data = 8'($urandom);
        r.new_size = 14'($urandom_range(0, 8192));
        pick = $urandom_range(0, 99);
        if (pick < 8) r.mode = MODE_CREATE;
        else if (pick < 28) r.mode = MODE_SIZE;
        else if (pick < 66) r.mode = MODE_WRITE;
        else r.mode = MODE_READ;
        if ($urandom_range(0, 99) < 88) begin
            f = $urandom_range(0, NUM_FILES - 1);
            tries = 0;
            while (fat_sb.head_of[f] == HEAD_FREE && tries < NUM_FILES) begin
                f = (f + 1) % NUM_FILES;
                tries++;
            end
            r.file_id = f[5:0];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                lim = fat_sb.cap_of[f] + BLOCK_BYTES - 1;
                if (lim > 8191) lim = 8191;
                r.position = 13'($urandom_range(0, lim));
            end else if (pick < 85 && fat_sb.len_of[f] > 0) begin
                r.position = 13'($urandom_range(0, fat_sb.len_of[f] - 1));
            end
        end
        // Sizes stay small mostly; big grows are slow and rare.
        pick = $urandom_range(0, 99);
        if (pick < 80) r.new_size = 14'($urandom_range(0, 640));
        else if (pick < 96) r.new_size = 14'($urandom_range(0, 4096));
        return r;
    endfunction

    initial begin
        int burst;
        cycle_count = 0;
        fat_sb = new();
        start <= 1'b0;
        i_req <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty read, byte extremes, exhausting the block table, skipped
        // bytes, shrink with length clamp, dead files.
        send_beat(mk_req(MODE_READ, 0, 0, 0, 0));
        send_beat(mk_req(MODE_WRITE, 0, 0, 0, 8'hFF));
        send_beat(mk_req(MODE_READ, 0, 0, 0, 0));
        send_beat(mk_req(MODE_WRITE, 0, 8191, 0, 8'hA5));
        send_beat(mk_req(MODE_SIZE, 0, 0, 8192, 0));
        send_beat(mk_req(MODE_SIZE, 0, 0, 8128, 0));
        send_beat(mk_req(MODE_CREATE, 0, 0, 0, 0));
        send_beat(mk_req(MODE_WRITE, 0, 8127, 0, 8'h00));
        send_beat(mk_req(MODE_READ, 0, 8127, 0, 0));
        send_beat(mk_req(MODE_READ, 0, 100, 0, 0));
        send_beat(mk_req(MODE_READ, 0, 8128, 0, 0));
        send_beat(mk_req(MODE_SIZE, 0, 0, 0, 0));
        send_beat(mk_req(MODE_READ, 0, 0, 0, 0));
        send_beat(mk_req(MODE_SIZE, 63, 0, 100, 0));
        send_beat(mk_req(MODE_WRITE, 63, 5, 0, 8'h3C));
        send_beat(mk_req(MODE_READ, 63, 5, 0, 0));
        send_beat(mk_req(MODE_CREATE, 0, 0, 0, 0));
        send_beat(mk_req(MODE_WRITE, 1, 200, 0, 8'h5A));
        send_beat(mk_req(MODE_READ, 1, 150, 0, 0));
        send_beat(mk_req(MODE_SIZE, 1, 0, 64, 0));
        send_beat(mk_req(MODE_READ, 1, 64, 0, 0));
        idle_cycles(1);

        // Random bursts with random gaps; a zero gap keeps start high. Halfway
        // the sender waits for the response queue to drain.
        for (int n = 0; n < RANDOM_BEATS; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < RANDOM_BEATS; k++, n++) begin
                send_beat(rand_req());
                if (n == RANDOM_BEATS / 2) begin
                    start <= 1'b0;
                    while (fat_sb.pending_rsp.size() != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
        end
        start <= 1'b0;

        while (fat_sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fat_sb.mismatches == 0 && fat_sb.pending_rsp.size() == 0) begin
            $display("chained_block_file_store regression: pass");
        end else begin
            $display("chained_block_file_store regression: fail");
        end
        $finish;
    end

endmodule
